[hw/rtl/wse_pkg.sv]
// Shared types, constants and helpers of the wheel speed estimator.
package wse_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 17;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LEFT_CPM   = 2'd0,
    CFG_RIGHT_CPM  = 2'd1,
    CFG_DEFAULT_MS = 2'd2,
    CFG_WEIGHT     = 2'd3
  } cfg_index_t;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  localparam int WEIGHT_W    = 17;
  localparam int WEIGHT_FRAC = 16;
  localparam int MUL_STEPS   = WEIGHT_W;

  localparam logic [15:0]         CPM_RESET    = 16'd1867;
  localparam logic [15:0]         MS_RESET     = 16'd10;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd22938;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
  localparam logic [19:0]         SPEED_SCALE  = 20'd1000000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_HALF  = 17'd32768;

  typedef struct packed {
    logic [15:0]         left_cpm;
    logic [15:0]         right_cpm;
    logic [15:0]         default_ms;
    logic [WEIGHT_W-1:0] weight;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic prep;
    logic div_step;
    logic filt;
    logic mul_step;
    logic upd;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [31:0] raw_speed;
    logic [31:0] filt_speed;
    logic [31:0] total;
  } lane_out_t;

  // Apply sign to a magnitude and saturate to signed 32 bit.
  function automatic logic [31:0] sat_s32(input logic neg, input logic [63:0] mag);
    logic [63:0] negm;
    logic [31:0] res;
    negm = -mag;
    if (neg) begin
      res = (mag > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : negm[31:0];
    end else begin
      res = (mag > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return res;
  endfunction

endpackage

[hw/rtl/wse_if.sv]
// Request, result and configuration channels of the wheel speed estimator.
interface wse_item_if #(parameter int DELTA_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic signed [DELTA_BITS-1:0] left_ticks;
  logic signed [DELTA_BITS-1:0] right_ticks;
  logic [15:0]                  period_ms;

  modport source (output valid, op, left_ticks, right_ticks, period_ms, input ready);
  modport sink (input valid, op, left_ticks, right_ticks, period_ms, output ready);
endinterface

interface wse_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] raw_left_speed;
  logic signed [31:0] raw_right_speed;
  logic signed [31:0] filtered_left_speed;
  logic signed [31:0] filtered_right_speed;
  logic signed [31:0] left_total;
  logic signed [31:0] right_total;

  modport source (output valid, raw_left_speed, raw_right_speed, filtered_left_speed,
                  filtered_right_speed, left_total, right_total, input ready);
  modport sink (input valid, raw_left_speed, raw_right_speed, filtered_left_speed,
                filtered_right_speed, left_total, right_total, output ready);
endinterface

interface wse_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [wse_pkg::CFG_INDEX_W-1:0]    index;
  logic [wse_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/wse_cfg.sv]
// Configuration registers with their effective values.
module wse_cfg (
  input  logic          clk,
  input  logic          rst,
  wse_cfg_if.sink       cfg,
  output wse_pkg::cfg_t eff
);

  logic [15:0]                  left_cpm;
  logic [15:0]                  right_cpm;
  logic [15:0]                  default_ms;
  logic [wse_pkg::WEIGHT_W-1:0] weight;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_cpm   <= wse_pkg::CPM_RESET;
      right_cpm  <= wse_pkg::CPM_RESET;
      default_ms <= wse_pkg::MS_RESET;
      weight     <= wse_pkg::WEIGHT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (wse_pkg::cfg_index_t'(cfg.index))
        wse_pkg::CFG_LEFT_CPM:   left_cpm   <= cfg.data[15:0];
        wse_pkg::CFG_RIGHT_CPM:  right_cpm  <= cfg.data[15:0];
        wse_pkg::CFG_DEFAULT_MS: default_ms <= cfg.data[15:0];
        wse_pkg::CFG_WEIGHT:     weight     <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff.left_cpm   = (left_cpm == 16'd0) ? 16'd1 : left_cpm;
    eff.right_cpm  = (right_cpm == 16'd0) ? 16'd1 : right_cpm;
    eff.default_ms = (default_ms == 16'd0) ? 16'd1 : default_ms;
    eff.weight     = (weight > wse_pkg::WEIGHT_ONE) ? wse_pkg::WEIGHT_ONE : weight;
  end

endmodule

[hw/rtl/wse_ctrl.sv]
// Sequencing state machine of the wheel speed estimator.
module wse_ctrl #(
  parameter int DIV_STEPS = 51
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_op,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output wse_pkg::cmd_t cmd
);

  localparam int MAX_STEPS = (DIV_STEPS > wse_pkg::MUL_STEPS) ? DIV_STEPS : wse_pkg::MUL_STEPS;
  localparam int CNT_W = $clog2(MAX_STEPS + 1);
  localparam logic [CNT_W-1:0] LAST_DIV = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] LAST_MUL = CNT_W'(wse_pkg::MUL_STEPS - 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PREP = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_FILT = 7'b0001000,
    ST_MUL  = 7'b0010000,
    ST_UPD  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          if (in_op == wse_pkg::OP_CLEAR) begin
            cmd.clear  = 1'b1;
            state_next = ST_OUT;
          end else begin
            cmd.load   = 1'b1;
            state_next = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == LAST_DIV) begin
          cnt_next   = '0;
          state_next = ST_FILT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_FILT: begin
        cmd.filt   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (cnt == LAST_MUL) begin
          cnt_next   = '0;
          state_next = ST_UPD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_UPD: begin
        cmd.upd    = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

  a_filt_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILT) |-> ($past(state) == ST_DIV))
    else $error("filter stage entered without division");

  a_mul_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (cnt <= LAST_MUL))
    else $error("multiply step count out of range");

endmodule

[hw/rtl/wse_lane.sv]
// Per-wheel datapath: total, serial divider, serial weight multiply and filter.
module wse_lane #(
  parameter int FRAC_BITS  = 16,
  parameter int DELTA_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  wse_pkg::cmd_t                cmd,
  input  logic signed [DELTA_BITS-1:0] delta,
  input  logic [15:0]                  ms,
  input  logic [15:0]                  cpm,
  input  logic [wse_pkg::WEIGHT_W-1:0] weight,
  output wse_pkg::lane_out_t           res
);

  localparam int NW   = DELTA_BITS + 19;
  localparam int DVW  = NW + FRAC_BITS;
  localparam int FW   = 32 + FRAC_BITS;
  localparam int PW   = FW + wse_pkg::WEIGHT_W;
  localparam int CMPW = (DVW > FW) ? DVW : FW;
  localparam logic [FW-1:0] LIM_POS = {1'b0, {(FW-1){1'b1}}};
  localparam logic [FW-1:0] LIM_NEG = {1'b1, {(FW-1){1'b0}}};
  localparam logic [PW-1:0] HALF_W  = PW'(wse_pkg::WEIGHT_HALF);
  localparam logic [FW:0]   HALF_F  = (FW+1)'(1) << (FRAC_BITS - 1);

  logic                         neg;
  logic [DELTA_BITS-1:0]        mag_in;
  logic [31:0]                  den;
  logic [DVW-1:0]               quot;
  logic [31:0]                  rem;
  logic                         dneg;
  logic [PW-1:0]                mcand;
  logic [PW-1:0]                acc;
  logic [wse_pkg::WEIGHT_W-1:0] wsh;
  logic signed [FW-1:0]         filt;
  logic [31:0]                  total;
  logic [31:0]                  raw_int;

  logic [NW:0]          prod_n;
  logic [32:0]          rem_sh;
  logic [32:0]          rem_sub;
  logic                 ge;
  logic [FW-1:0]        lim;
  logic [FW-1:0]        mag_q;
  logic signed [FW-1:0] raw_q;
  logic signed [FW:0]   diff;
  logic [FW:0]          dabs;
  logic [NW:0]          rm;
  logic [PW-1:0]        rnd;
  logic [FW:0]          step;
  logic [FW+1:0]        filt_sum;
  logic [FW-1:0]        fabs;
  logic [FW:0]          frnd;
  logic [31:0]          filt_int;

  assign prod_n  = (NW+1)'(mag_in) * (NW+1)'(wse_pkg::SPEED_SCALE);
  assign rem_sh  = {rem, quot[DVW-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign ge      = (rem_sh >= {1'b0, den});

  assign lim   = neg ? LIM_NEG : LIM_POS;
  assign mag_q = (CMPW'(quot) > CMPW'(lim)) ? lim : FW'(CMPW'(quot));
  assign raw_q = neg ? -$signed(mag_q) : $signed(mag_q);
  assign diff  = {raw_q[FW-1], raw_q} - {filt[FW-1], filt};
  assign dabs  = diff[FW] ? (FW+1)'(-diff) : (FW+1)'(diff);
  assign rm    = (NW+1)'(quot[DVW-1:FRAC_BITS]) + (NW+1)'(quot[FRAC_BITS-1]);

  assign rnd      = acc + HALF_W;
  assign step     = rnd[PW-1:wse_pkg::WEIGHT_FRAC];
  assign filt_sum = dneg ? ({{2{filt[FW-1]}}, filt} - {1'b0, step})
                         : ({{2{filt[FW-1]}}, filt} + {1'b0, step});

  assign fabs     = filt[FW-1] ? FW'(-filt) : FW'(filt);
  assign frnd     = {1'b0, fabs} + HALF_F;
  assign filt_int = wse_pkg::sat_s32(filt[FW-1], 64'(frnd[FW:FRAC_BITS]));

  always_ff @(posedge clk) begin
    if (rst) begin
      filt  <= '0;
      total <= '0;
    end else if (cmd.clear) begin
      filt  <= '0;
      total <= '0;
    end else begin
      if (cmd.load) begin
        total <= total + 32'(delta);
      end
      if (cmd.upd) begin
        filt <= filt_sum[FW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      raw_int <= '0;
    end
    if (cmd.load) begin
      neg    <= delta[DELTA_BITS-1];
      mag_in <= delta[DELTA_BITS-1] ? DELTA_BITS'(-delta) : DELTA_BITS'(delta);
      den    <= 32'(cpm) * 32'(ms);
    end
    if (cmd.prep) begin
      quot <= {prod_n[NW-1:0], {FRAC_BITS{1'b0}}};
      rem  <= '0;
    end
    if (cmd.div_step) begin
      rem  <= ge ? rem_sub[31:0] : rem_sh[31:0];
      quot <= {quot[DVW-2:0], ge};
    end
    if (cmd.filt) begin
      raw_int <= wse_pkg::sat_s32(neg, 64'(rm));
      dneg    <= diff[FW];
      mcand   <= PW'(dabs);
      acc     <= '0;
      wsh     <= weight;
    end
    if (cmd.mul_step) begin
      acc   <= acc + (wsh[0] ? mcand : '0);
      mcand <= mcand << 1;
      wsh   <= wsh >> 1;
    end
    if (cmd.load_out) begin
      res.raw_speed  <= raw_int;
      res.filt_speed <= filt_int;
      res.total      <= total;
    end
  end

endmodule

[hw/rtl/wheel_speed_estimator.sv]
// Wheel speed estimator top level: encoder deltas to raw and filtered wheel speeds.
// An update request passes through the prepare, divide, filter, multiply and update states;
// the bit-serial restoring divider gives one quotient bit per cycle over DELTA_BITS +
// FRAC_BITS + 19 steps, and the 17-step shift-add weight multiply follows, both lanes
// running side by side. A clear request goes straight to the output state. The result
// sits in an output register, so a new request is taken while a result waits.
module wheel_speed_estimator #(
  parameter int FRAC_BITS  = 16,
  parameter int DELTA_BITS = 16
) (
  input logic          clk,
  input logic          rst,
  wse_item_if.sink     item,
  wse_result_if.source result,
  wse_cfg_if.sink      cfg
);

  localparam int DIV_STEPS = DELTA_BITS + 19 + FRAC_BITS;

  wse_pkg::cfg_t                eff;
  wse_pkg::cmd_t                cmd;
  wse_pkg::lane_out_t           left_res;
  wse_pkg::lane_out_t           right_res;
  logic [15:0]                  ms_sel;
  logic signed [DELTA_BITS-1:0] left_ticks;
  logic signed [DELTA_BITS-1:0] right_ticks;
  logic                         in_ready;
  logic                         out_valid;

  assign left_ticks  = DELTA_BITS'(item.left_ticks);
  assign right_ticks = DELTA_BITS'(item.right_ticks);
  assign ms_sel      = (item.period_ms == 16'd0) ? eff.default_ms : item.period_ms;

  wse_cfg u_cfg (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .eff (eff)
  );

  wse_ctrl #(.DIV_STEPS(DIV_STEPS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_op     (item.op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  wse_lane #(.FRAC_BITS(FRAC_BITS), .DELTA_BITS(DELTA_BITS)) u_left (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .delta  (left_ticks),
    .ms     (ms_sel),
    .cpm    (eff.left_cpm),
    .weight (eff.weight),
    .res    (left_res)
  );

  wse_lane #(.FRAC_BITS(FRAC_BITS), .DELTA_BITS(DELTA_BITS)) u_right (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .delta  (right_ticks),
    .ms     (ms_sel),
    .cpm    (eff.right_cpm),
    .weight (eff.weight),
    .res    (right_res)
  );

  assign item.ready                  = in_ready;
  assign result.valid                = out_valid;
  assign result.raw_left_speed       = left_res.raw_speed;
  assign result.raw_right_speed      = right_res.raw_speed;
  assign result.filtered_left_speed  = left_res.filt_speed;
  assign result.filtered_right_speed = right_res.filt_speed;
  assign result.left_total           = left_res.total;
  assign result.right_total          = right_res.total;

endmodule

[bench/tb_wheel_speed_estimator.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the wheel speed estimator with a bit-accurate speed predictor.
module tb_wheel_speed_estimator;

  localparam int FRAC           = 16;
  localparam int IDLE_PCT       = 17;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 100;
  localparam logic [63:0] Q_LIMIT = 64'd1 << (31 + FRAC);
  localparam logic signed [15:0] DELTA_MAX = 16'sh7FFF;
  localparam logic signed [15:0] DELTA_MIN = 16'sh8000;

  // [0] raw left, [1] raw right, [2] filtered left, [3] filtered right, [4..5] totals
  typedef logic [5:0][31:0] report_t;

  logic clk;
  logic rst;

  wse_item_if #(.DELTA_BITS(16)) item_ch ();
  wse_result_if                  result_ch ();
  wse_cfg_if                     cfg_ch ();

  wheel_speed_estimator DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  logic [15:0]        lcpm_reg;
  logic [15:0]        rcpm_reg;
  logic [15:0]        dms_reg;
  logic [16:0]        weight_reg;
  logic [31:0]        left_sum;
  logic [31:0]        right_sum;
  logic signed [63:0] left_filt;
  logic signed [63:0] right_filt;

  report_t pending_reports[$];
  string   field_name [6] = '{"raw_left_speed", "raw_right_speed", "filtered_left_speed",
                              "filtered_right_speed", "left_total", "right_total"};
  int errors;
  int requests_sent;
  int clears_sent;
  int results_seen;
  int settings_used;
  int quiet_cycles;
  bit sender_gaps;
  bit receiver_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] clamp_s32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] speed_q16(input logic signed [15:0] delta,
                                                   input logic [63:0] cpm,
                                                   input logic [63:0] ms,
                                                   output logic signed [63:0] rounded);
    logic signed [63:0] d;
    logic neg;
    logic [63:0] m, den, n, q, r, lim, mag, rm;
    d = 64'(delta);
    neg = delta[15];
    m = neg ? -d : d;
    den = cpm * ms;
    n = m * 64'd1000000;
    q = n / den;
    r = n % den;
    lim = neg ? Q_LIMIT : Q_LIMIT - 64'd1;
    rm = (64'd2 * n + den) / (64'd2 * den);
    rounded = neg ? -$signed(rm) : $signed(rm);
    if (q >= 64'h1_0000_0000) begin
      mag = lim;
    end else begin
      mag = (q << FRAC) | ((r << FRAC) / den);
      if (mag > lim) mag = lim;
    end
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [63:0] filter_next(input logic signed [63:0] old,
                                                     input logic signed [63:0] target,
                                                     input logic [63:0] w);
    logic signed [63:0] diff;
    logic [63:0] m, step;
    diff = target - old;
    m = (diff < 0) ? -diff : diff;
    step = (m >> 16) * w + (((m & 64'hFFFF) * w + 64'h8000) >> 16);
    return (diff < 0) ? old - $signed(step) : old + $signed(step);
  endfunction

  function automatic logic [31:0] round_q16(input logic signed [63:0] v);
    logic [63:0] m, r;
    m = (v < 0) ? -v : v;
    r = (m + (64'd1 << (FRAC - 1))) >> FRAC;
    return clamp_s32((v < 0) ? -$signed(r) : $signed(r));
  endfunction

  function automatic report_t predict_speeds(input wse_pkg::op_t op,
                                             input logic signed [15:0] ld,
                                             input logic signed [15:0] rd,
                                             input logic [15:0] ms_in);
    report_t rep;
    logic [63:0] ms, lc, rc, w;
    logic signed [63:0] lraw, rraw, lq, rq;
    if (op == wse_pkg::OP_CLEAR) begin
      left_sum = '0;
      right_sum = '0;
      left_filt = '0;
      right_filt = '0;
      return '0;
    end
    if (ms_in != 0) ms = 64'(ms_in);
    else if (dms_reg != 0) ms = 64'(dms_reg);
    else ms = 64'd1;
    lc = (lcpm_reg != 0) ? 64'(lcpm_reg) : 64'd1;
    rc = (rcpm_reg != 0) ? 64'(rcpm_reg) : 64'd1;
    w = (weight_reg > wse_pkg::WEIGHT_ONE) ? 64'(wse_pkg::WEIGHT_ONE) : 64'(weight_reg);
    left_sum = left_sum + {{16{ld[15]}}, ld};
    right_sum = right_sum + {{16{rd[15]}}, rd};
    lq = speed_q16(ld, lc, ms, lraw);
    rq = speed_q16(rd, rc, ms, rraw);
    left_filt = filter_next(left_filt, lq, w);
    right_filt = filter_next(right_filt, rq, w);
    rep[0] = clamp_s32(lraw);
    rep[1] = clamp_s32(rraw);
    rep[2] = round_q16(left_filt);
    rep[3] = round_q16(right_filt);
    rep[4] = left_sum;
    rep[5] = right_sum;
    return rep;
  endfunction

  function automatic logic signed [15:0] random_delta();
    case ($urandom_range(5))
      0: return 16'sd0;
      1: return $urandom_range(1) ? DELTA_MAX : DELTA_MIN;
      2, 3: return 16'(int'($urandom_range(4000)) - 2000);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_request(input wse_pkg::op_t op, input logic signed [15:0] ld,
                              input logic signed [15:0] rd, input logic [15:0] ms);
    while (sender_gaps && $urandom_range(99) < IDLE_PCT) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.op <= op;
    item_ch.left_ticks <= ld;
    item_ch.right_ticks <= rd;
    item_ch.period_ms <= ms;
    do @(posedge clk); while (!item_ch.ready);
    pending_reports.push_back(predict_speeds(op, ld, rd, ms));
    requests_sent++;
    if (op == wse_pkg::OP_CLEAR) clears_sent++;
  endtask

  task automatic wait_for_results();
    item_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input wse_pkg::cfg_index_t idx, input logic [16:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      wse_pkg::CFG_LEFT_CPM:   lcpm_reg = value[15:0];
      wse_pkg::CFG_RIGHT_CPM:  rcpm_reg = value[15:0];
      wse_pkg::CFG_DEFAULT_MS: dms_reg = value[15:0];
      wse_pkg::CFG_WEIGHT:     weight_reg = value;
      default: begin
      end
    endcase
  endtask

  task automatic apply_settings(input logic [16:0] lcpm, input logic [16:0] rcpm,
                                input logic [16:0] dms, input logic [16:0] w);
    wait_for_results();
    write_reg(wse_pkg::CFG_LEFT_CPM, lcpm);
    write_reg(wse_pkg::CFG_RIGHT_CPM, rcpm);
    write_reg(wse_pkg::CFG_DEFAULT_MS, dms);
    write_reg(wse_pkg::CFG_WEIGHT, w);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic apply_reset_settings();
    apply_settings(17'(wse_pkg::CPM_RESET), 17'(wse_pkg::CPM_RESET), 17'(wse_pkg::MS_RESET),
                   wse_pkg::WEIGHT_RESET);
  endtask

  task automatic random_requests(input int count);
    wse_pkg::op_t op;
    logic [15:0] ms;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(31) == 0) ? wse_pkg::OP_CLEAR : wse_pkg::OP_UPDATE;
      case ($urandom_range(7))
        0: ms = 16'd0;
        1, 2, 3, 4: ms = 16'($urandom_range(1, 50));
        default: ms = 16'($urandom);
      endcase
      send_request(op, random_delta(), random_delta(), ms);
    end
  endtask

  task automatic test_default_settings();
    send_request(wse_pkg::OP_UPDATE, 16'sd0, 16'sd0, 16'd0);
    send_request(wse_pkg::OP_UPDATE, DELTA_MAX, DELTA_MIN, 16'd1);
    send_request(wse_pkg::OP_UPDATE, DELTA_MIN, DELTA_MAX, 16'hFFFF);
    send_request(wse_pkg::OP_UPDATE, 16'sd1867, -16'sd1867, 16'd0);
  endtask

  task automatic test_clear_request();
    send_request(wse_pkg::OP_CLEAR, DELTA_MAX, DELTA_MIN, 16'hFFFF);
    send_request(wse_pkg::OP_UPDATE, 16'sd100, -16'sd100, 16'd7);
    send_request(wse_pkg::OP_CLEAR, 16'sd0, 16'sd0, 16'd0);
  endtask

  task automatic test_extreme_settings();
    apply_settings(17'd1, 17'd1, 17'd1, wse_pkg::WEIGHT_ONE);
    send_request(wse_pkg::OP_UPDATE, DELTA_MAX, DELTA_MIN, 16'd0);
    send_request(wse_pkg::OP_UPDATE, DELTA_MAX, DELTA_MIN, 16'd1);
    send_request(wse_pkg::OP_CLEAR, 16'sd0, 16'sd0, 16'd0);
    apply_settings(17'h10000, 17'h10000, 17'h10000, 17'h1FFFF);
    send_request(wse_pkg::OP_UPDATE, -16'sd1, 16'sd1, 16'd0);
    send_request(wse_pkg::OP_UPDATE, 16'sd5, -16'sd5, 16'd0);
    apply_settings(17'h0FFFF, 17'h1FFFF, 17'h0FFFF, 17'd0);
    send_request(wse_pkg::OP_UPDATE, DELTA_MAX, DELTA_MIN, 16'hFFFF);
    send_request(wse_pkg::OP_UPDATE, 16'sd1, -16'sd1, 16'd1);
  endtask

  task automatic test_rounding_ties();
    apply_settings(17'd40000, 17'd40000, 17'd10, wse_pkg::WEIGHT_HALF);
    send_request(wse_pkg::OP_UPDATE, 16'sd1, -16'sd1, 16'd0);
    send_request(wse_pkg::OP_UPDATE, 16'sd3, -16'sd3, 16'd10);
    send_request(wse_pkg::OP_UPDATE, -16'sd5, 16'sd5, 16'd10);
    apply_reset_settings();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
        end
        1: apply_settings(17'($urandom_range(200, 5000)), 17'($urandom_range(200, 5000)),
                          17'($urandom_range(1, 100)),
                          17'($urandom_range(0, wse_pkg::WEIGHT_ONE)));
        2: apply_settings(17'd1, 17'd1, 17'd1, wse_pkg::WEIGHT_ONE);
        3: apply_settings(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom));
        4: apply_settings(17'h0FFFF, 17'h0FFFF, 17'($urandom_range(1, 20)),
                          17'($urandom_range(0, 16)));
        default: begin
          apply_reset_settings();
          sender_gaps = 1'b0;
          receiver_gaps = 1'b0;
        end
      endcase
      random_requests(128);
      if (phase == 1) wait_for_results();
      random_requests(128);
    end
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) result_ch.ready <= 1'b0;
    else result_ch.ready <= !(receiver_gaps && $urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin : result_check
    report_t got;
    report_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = {result_ch.right_total, result_ch.left_total, result_ch.filtered_right_speed,
             result_ch.filtered_left_speed, result_ch.raw_right_speed,
             result_ch.raw_left_speed};
      results_seen++;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, expected none actual %h", $time, got);
      end else begin
        want = pending_reports.pop_front();
        for (int k = 0; k < 6; k++) begin
          if (got[k] !== want[k]) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, field_name[k],
                     $signed(want[k]), $signed(got[k]));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.op = wse_pkg::OP_UPDATE;
    item_ch.left_ticks = '0;
    item_ch.right_ticks = '0;
    item_ch.period_ms = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = wse_pkg::CFG_LEFT_CPM;
    cfg_ch.data = '0;
    lcpm_reg = wse_pkg::CPM_RESET;
    rcpm_reg = wse_pkg::CPM_RESET;
    dms_reg = wse_pkg::MS_RESET;
    weight_reg = wse_pkg::WEIGHT_RESET;
    left_sum = '0;
    right_sum = '0;
    left_filt = '0;
    right_filt = '0;
    requests_sent = 0;
    clears_sent = 0;
    settings_used = 0;
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_default_settings();
    test_clear_request();
    test_extreme_settings();
    test_rounding_ties();
    test_random_traffic();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests (%0d clears) and %0d results checked over %0d register settings",
             requests_sent, clears_sent, results_seen, settings_used);
    $display("saturation, rounding ties, zero and oversized registers, stalls on both sides");
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/wse_pkg.sv
hw/rtl/wse_if.sv
hw/rtl/wse_cfg.sv
hw/rtl/wse_ctrl.sv
hw/rtl/wse_lane.sv
hw/rtl/wheel_speed_estimator.sv
bench/tb_wheel_speed_estimator.sv
